// ----- sv/itoa_pkg.sv -----
// Shared types, constants and helpers for the integer to ASCII converter.
package itoa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 8;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;
    localparam int DIV_W      = DIGIT_W + 1;
    localparam int DIV_CHUNK  = 8;
    localparam int DIV_STEPS  = VALUE_BITS / DIV_CHUNK;
    localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int COUNT_W    = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int SHIFT_W    = 3;
    localparam int JOBQ_DEPTH = 2;
    localparam int JQ_PTR_W   = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
    localparam int JQ_CNT_W   = $clog2(JOBQ_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd16;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 8'd10;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] number;
        logic [RADIX_W-1:0]           radix;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_base;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_BAD,
        JOB_ZERO,
        JOB_CONV
    } job_kind_t;

    typedef struct packed {
        job_kind_t             kind;
        logic                  negative;
        logic                  pow2;
        logic [SHIFT_W-1:0]    shift;
        logic [DIV_W-1:0]      radix;
        logic [VALUE_BITS-1:0] magnitude;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SINGLE,
        BK_DIV,
        BK_SIGN,
        BK_READ,
        BK_LOAD
    } back_state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DIGIT_W'(10))
            ch = CH_ZERO + CHAR_W'(d);
        else
            ch = CH_A + CHAR_W'(d - DIGIT_W'(10));
        return ch;
    endfunction

endpackage

// ----- sv/itoa_front.sv -----
// Front end: classifies an incoming item and forms the job for the digit engine.
module itoa_front (
    input  itoa_pkg::in_item_t item,
    output itoa_pkg::job_t     job
);
    import itoa_pkg::*;

    logic [VALUE_BITS-1:0] pattern;
    logic                  bad;
    logic                  neg;

    always_comb
    begin
        pattern = VALUE_BITS'(item.number);
        bad     = (item.radix < RADIX_MIN) || (item.radix > RADIX_MAX);
        // sign is only shown in decimal; other radices see the raw bit pattern
        neg     = pattern[VALUE_BITS-1] && (item.radix == RADIX_DEC);

        job.negative  = neg;
        job.magnitude = neg ? (VALUE_BITS'(0) - pattern) : pattern;
        job.radix     = item.radix[DIV_W-1:0];
        job.pow2      = 1'b0;
        job.shift     = '0;
        case (item.radix)
            8'd2:
            begin
                job.pow2  = 1'b1;
                job.shift = SHIFT_W'(1);
            end
            8'd4:
            begin
                job.pow2  = 1'b1;
                job.shift = SHIFT_W'(2);
            end
            8'd8:
            begin
                job.pow2  = 1'b1;
                job.shift = SHIFT_W'(3);
            end
            8'd16:
            begin
                job.pow2  = 1'b1;
                job.shift = SHIFT_W'(4);
            end
            default:
            begin
                job.pow2  = 1'b0;
                job.shift = '0;
            end
        endcase

        if (bad)
            job.kind = JOB_BAD;
        else if (pattern == '0)
            job.kind = JOB_ZERO;
        else
            job.kind = JOB_CONV;
    end

endmodule

// ----- sv/itoa_job_fifo.sv -----
// Short job queue between the classifier and the digit engine.
module itoa_job_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  itoa_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output itoa_pkg::job_t pop_data,
    output logic           empty
);
    import itoa_pkg::*;

    job_t                entry_reg [JOBQ_DEPTH];
    logic [JQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JQ_CNT_W-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == JQ_CNT_W'(JOBQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == JQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == JQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/itoa_back.sv -----
// Digit engine: divides out digits into the digit memory, then emits characters.
module itoa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_empty,
    input  itoa_pkg::job_t    job,
    output logic              job_pop,
    output itoa_pkg::out_item_t result,
    output logic              empty,
    input  logic              pop
);
    import itoa_pkg::*;

    logic [DIGIT_W-1:0]    digit_mem [VALUE_BITS];
    logic [DIGIT_W-1:0]    rd_data_reg;

    back_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] work_reg, work_next;
    logic [DIGIT_W-1:0]    part_reg, part_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  neg_reg, neg_next;
    logic                  pow2_reg, pow2_next;
    logic [SHIFT_W-1:0]    shift_reg, shift_next;
    logic [DIV_W-1:0]      radix_reg, radix_next;
    logic                  bad_reg, bad_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;

    logic                  slot_free;
    logic                  mem_we;
    logic [DIGIT_W-1:0]    digit;
    logic [VALUE_BITS-1:0] quot;
    logic                  digit_done;
    logic [DIV_W-1:0]      part;
    logic [DIV_CHUNK-1:0]  chunk, qchunk;

    assign slot_free = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    // one chunk of restoring division against the radix, or a shift for powers of two
    always_comb
    begin
        chunk  = work_reg[VALUE_BITS-1 -: DIV_CHUNK];
        qchunk = '0;
        part   = DIV_W'(part_reg);
        for (int i = DIV_CHUNK - 1; i >= 0; i--)
        begin
            part = {part[DIGIT_W-1:0], chunk[i]};
            if (part >= radix_reg)
            begin
                part      = part - radix_reg;
                qchunk[i] = 1'b1;
            end
        end
        if (pow2_reg)
        begin
            digit      = work_reg[DIGIT_W-1:0] & DIGIT_W'(radix_reg - 1'b1);
            quot       = work_reg >> shift_reg;
            digit_done = 1'b1;
        end
        else
        begin
            digit      = part[DIGIT_W-1:0];
            quot       = (work_reg << DIV_CHUNK) | VALUE_BITS'(qchunk);
            digit_done = (step_reg == STEP_W'(DIV_STEPS - 1));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        part_next      = part_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        pow2_next      = pow2_reg;
        shift_next     = shift_reg;
        radix_next     = radix_reg;
        bad_next       = bad_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        job_pop        = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    bad_next   = (job.kind == JOB_BAD);
                    neg_next   = job.negative;
                    pow2_next  = job.pow2;
                    shift_next = job.shift;
                    radix_next = job.radix;
                    work_next  = job.magnitude;
                    part_next  = '0;
                    step_next  = '0;
                    count_next = '0;
                    if (job.kind == JOB_CONV)
                        state_next = BK_DIV;
                    else
                        state_next = BK_SINGLE;
                end
            end
            BK_SINGLE:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.character = bad_reg ? CH_NUL : CH_ZERO;
                    out_next.last      = 1'b1;
                    out_next.bad_base  = bad_reg;
                    state_next         = BK_IDLE;
                end
            end
            BK_DIV:
            begin
                if (digit_done)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    work_next  = quot;
                    part_next  = '0;
                    step_next  = '0;
                    if ((quot == '0) || (count_reg == COUNT_W'(VALUE_BITS - 1)))
                    begin
                        idx_next   = count_reg[IDX_W-1:0];
                        state_next = neg_reg ? BK_SIGN : BK_READ;
                    end
                end
                else
                begin
                    work_next = quot;
                    part_next = part[DIGIT_W-1:0];
                    step_next = step_reg + 1'b1;
                end
            end
            BK_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.character = CH_MINUS;
                    out_next.last      = 1'b0;
                    out_next.bad_base  = 1'b0;
                    state_next         = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_LOAD;
            end
            BK_LOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.character = digit_char(rd_data_reg);
                    out_next.last      = (idx_reg == '0);
                    out_next.bad_base  = 1'b0;
                    if (idx_reg == '0)
                        state_next = BK_IDLE;
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            work_reg      <= '0;
            neg_reg       <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            work_reg      <= work_next;
            neg_reg       <= neg_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg  <= part_next;
        idx_reg   <= idx_next;
        pow2_reg  <= pow2_next;
        shift_reg <= shift_next;
        radix_reg <= radix_next;
        bad_reg   <= bad_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[count_reg[IDX_W-1:0]] <= digit;
        if (state_reg == BK_READ)
            rd_data_reg <= digit_mem[idx_reg];
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(VALUE_BITS))
        else $error("digit count beyond value width");

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.bad_base) |-> out_reg.last)
        else $error("bad radix result not marked last");

    a_minus_only_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SIGN) |-> neg_reg)
        else $error("minus sign for a non-negative conversion");

    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LOAD && slot_free && idx_reg == '0) |=> (state_reg == BK_IDLE))
        else $error("engine did not return to idle after final digit");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (state_reg == BK_IDLE && !job_empty))
        else $error("job taken while engine busy");
`endif

endmodule

// ----- sv/integer_to_ascii_radix.sv -----
// Top level of the integer to ASCII converter for radix 2 to 16.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------
//  input    | push / full        | item   : number, radix
//  result   | pop / empty        | result : character, last, bad_base
//
// Power-of-two radices produce one digit per cycle; other radices take each digit
// through the shared chunked divider (eight quotient bits a cycle).
// Each character then passes through the digit memory's registered read (BK_READ, then BK_LOAD).
// Bad radix and zero give a single result through the BK_SINGLE state, which
// waits for a free result slot.
// Reset clears the control state; the digit memory needs no clearing.
// A two-entry job queue lets new items enter while the engine is busy or stalled.
module integer_to_ascii_radix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  itoa_pkg::in_item_t  item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output itoa_pkg::out_item_t result
);
    import itoa_pkg::*;

    job_t job_in;
    job_t job_out;
    logic job_empty;
    logic job_pop;

    itoa_front u_front (
        .item (item),
        .job  (job_in)
    );

    itoa_job_fifo u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (job_in),
        .full      (full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
